// ===== hw/rtl/inv_pkg.sv =====
package inv_pkg;

  localparam int MAX_SYMBOLS_DEF = 32;
  localparam int SYM_W = 8;
  localparam int TOT_W = 9;
  localparam logic [TOT_W-1:0] TOT_MAX = '1;

  typedef struct packed {
    logic valid;
    logic last;
    logic placed;
  } tok_ctl_t;

endpackage

// ===== hw/rtl/inv_cell.sv =====
module inv_cell #(
  parameter int CNT_W = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv_i,
  input  logic                                clr_i,
  input  inv_pkg::tok_ctl_t                   ctl_i,
  input  logic signed [inv_pkg::SYM_W-1:0]    sym_i,
  input  logic        [CNT_W-1:0]             cnt_i,
  output inv_pkg::tok_ctl_t                   ctl_o,
  output logic signed [inv_pkg::SYM_W-1:0]    sym_o,
  output logic        [CNT_W-1:0]             cnt_o,
  output logic                                full_o
);

  logic signed [inv_pkg::SYM_W-1:0] held_r;
  logic                             full_r;
  logic                             full_nxt;
  inv_pkg::tok_ctl_t                ctl_r;
  inv_pkg::tok_ctl_t                ctl_nxt;
  logic signed [inv_pkg::SYM_W-1:0] sym_r;
  logic        [CNT_W-1:0]          cnt_r;
  logic        [CNT_W-1:0]          cnt_nxt;
  logic                             gt;
  logic                             store;

  always_comb begin
    gt    = full_r && (held_r > sym_i);
    store = ctl_i.valid && !full_r && !ctl_i.placed;
    ctl_nxt        = ctl_i;
    ctl_nxt.placed = ctl_i.placed | store;
    cnt_nxt        = cnt_i + CNT_W'(gt);
    if (clr_i) begin
      full_nxt = 1'b0;
    end else if (adv_i && store) begin
      full_nxt = 1'b1;
    end else begin
      full_nxt = full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      ctl_r  <= '0;
    end else begin
      full_r <= full_nxt;
      if (adv_i) begin
        ctl_r <= ctl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      sym_r <= sym_i;
      cnt_r <= cnt_nxt;
      if (store) begin
        held_r <= sym_i;
      end
    end
  end

  assign ctl_o  = ctl_r;
  assign sym_o  = sym_r;
  assign cnt_o  = cnt_r;
  assign full_o = full_r;

endmodule

// ===== hw/rtl/inv_acc.sv =====
module inv_acc #(
  parameter int CNT_W = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  inv_pkg::tok_ctl_t             ctl_i,
  input  logic [CNT_W-1:0]              cnt_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [inv_pkg::TOT_W-1:0]     out_total_o,
  output logic                          out_ovf_o,
  output logic                          adv_o,
  output logic                          clr_o
);

  logic [inv_pkg::TOT_W-1:0] total_r;
  logic [inv_pkg::TOT_W-1:0] total_nxt;
  logic                      ovf_r;
  logic                      ovf_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [inv_pkg::TOT_W-1:0] out_total_r;
  logic                      out_ovf_r;
  logic [inv_pkg::TOT_W:0]   sum;
  logic [inv_pkg::TOT_W-1:0] upd_total;
  logic                      upd_ovf;
  logic                      take;

  always_comb begin
    adv_o = !(ctl_i.valid && ctl_i.last && out_valid_r && !out_ready_i);
    take  = ctl_i.valid && adv_o;
    clr_o = take && ctl_i.last;
    sum   = (inv_pkg::TOT_W+1)'(total_r) + (inv_pkg::TOT_W+1)'(cnt_i);
    if (!ctl_i.placed) begin
      upd_total = total_r;
    end else if (sum > (inv_pkg::TOT_W+1)'(inv_pkg::TOT_MAX)) begin
      upd_total = inv_pkg::TOT_MAX;
    end else begin
      upd_total = sum[inv_pkg::TOT_W-1:0];
    end
    upd_ovf = ovf_r | !ctl_i.placed;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready_i;
    if (take) begin
      if (ctl_i.last) begin
        total_nxt     = '0;
        ovf_nxt       = 1'b0;
        out_valid_nxt = 1'b1;
      end else begin
        total_nxt = upd_total;
        ovf_nxt   = upd_ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_o) begin
      out_total_r <= upd_total;
      out_ovf_r   <= upd_ovf;
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_total_o = out_total_r;
  assign out_ovf_o   = out_ovf_r;

endmodule

// ===== hw/rtl/inversion_counter.sv =====
// Inversion counter for sequences of signed 8-bit symbols.
// Input stream: in_tdata carries one symbol, in_tlast marks the final symbol
// of a sequence. Output stream: one transaction per sequence, holding the
// number of earlier/later pairs in which the earlier symbol is greater, and
// a flag that is set when symbols beyond the store capacity were dropped.
// Each symbol enters a chain of MAX_SYMBOLS cells and moves one cell per
// cycle unless the chain is frozen; each full cell compares its held symbol
// with the passing one, and the first empty cell keeps it. Symbols are
// accepted one per cycle while in_tready is high. After a tlast transaction
// in_tready stays low until that symbol has crossed the whole chain, and the
// result is registered as that symbol leaves the last cell. The next sequence
// may start while the result still waits in the output register.
// If the receiver stalls and a second result is ready, the chain freezes
// until the first result is taken.
// A synchronous reset empties the chain, the totals and the output register.
module inversion_counter #(
  parameter int MAX_SYMBOLS = inv_pkg::MAX_SYMBOLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [8:0] inversion_total, [9] overflow, [15:10] zero
);

  localparam int CNT_W = $clog2(MAX_SYMBOLS);

  inv_pkg::tok_ctl_t                ctl_w [0:MAX_SYMBOLS];
  logic signed [inv_pkg::SYM_W-1:0] sym_w [0:MAX_SYMBOLS];
  logic        [CNT_W-1:0]          cnt_w [0:MAX_SYMBOLS];
  logic        [MAX_SYMBOLS-1:0]    full_vec;
  logic                             adv;
  logic                             clr;
  logic                             busy_r;
  logic                             busy_nxt;
  logic                             in_acc;
  logic [inv_pkg::TOT_W-1:0]        out_total;
  logic                             out_ovf;

  assign in_tready = !busy_r && adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    ctl_w[0].valid  = in_acc;
    ctl_w[0].last   = in_tlast;
    ctl_w[0].placed = 1'b0;
    sym_w[0]        = in_tdata;
    cnt_w[0]        = '0;
  end

  for (genvar g = 0; g < MAX_SYMBOLS; g++) begin : g_cell
    inv_cell #(
      .CNT_W (CNT_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv_i  (adv),
      .clr_i  (clr),
      .ctl_i  (ctl_w[g]),
      .sym_i  (sym_w[g]),
      .cnt_i  (cnt_w[g]),
      .ctl_o  (ctl_w[g+1]),
      .sym_o  (sym_w[g+1]),
      .cnt_o  (cnt_w[g+1]),
      .full_o (full_vec[g])
    );
  end

  inv_acc #(
    .CNT_W (CNT_W)
  ) u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl_i       (ctl_w[MAX_SYMBOLS]),
    .cnt_i       (cnt_w[MAX_SYMBOLS]),
    .out_ready_i (out_tready),
    .out_valid_o (out_tvalid),
    .out_total_o (out_total),
    .out_ovf_o   (out_ovf),
    .adv_o       (adv),
    .clr_o       (clr)
  );

  always_comb begin
    busy_nxt = busy_r;
    if (in_acc && in_tlast) begin
      busy_nxt = 1'b1;
    end else if (clr) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign out_tdata = {6'b0, out_ovf, out_total};

`ifndef NO_ASSERTIONS
  localparam logic [MAX_SYMBOLS-1:0] ONE_V = MAX_SYMBOLS'(1);

  a_last_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_w[MAX_SYMBOLS].valid && ctl_w[MAX_SYMBOLS].last |-> busy_r)
    else $error("last symbol left the chain without a pending sequence end");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> full_vec == '0)
    else $error("cells not empty after sequence end");

  a_fill_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    ((full_vec + ONE_V) & full_vec) == '0)
    else $error("cells did not fill in order");

  a_freeze_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |-> out_tvalid && !out_tready)
    else $error("chain frozen without a stalled result");
`endif

endmodule

// ===== tb/inversion_counter_checker.sv =====
module inversion_counter_checker #(
  parameter int MAX_SYMBOLS = inv_pkg::MAX_SYMBOLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [8:0] inversion_total, [9] overflow, [15:10] zero
  output int unsigned failures,
  output int unsigned awaiting
);

  typedef struct {
    logic [inv_pkg::TOT_W-1:0] inversion_total;
    logic                      overflow;
  } tally_t;

  logic signed [inv_pkg::SYM_W-1:0] held_syms [MAX_SYMBOLS];
  int                               fill;
  int unsigned                      running;
  logic                             dropped;
  tally_t                           tally_q [$];
  int unsigned                      errs;

  // Compares the new symbol against every held one, then stores it; a full
  // store drops it and flags the sequence instead. A last symbol queues the tally.
  task automatic absorb_symbol(input logic signed [inv_pkg::SYM_W-1:0] sym,
                               input logic is_last);
    int unsigned greater;
    tally_t      done;
    greater = 0;
    if (fill < MAX_SYMBOLS) begin
      for (int i = 0; i < fill; i++) begin
        if (held_syms[i] > sym) greater++;
      end
      running = running + greater;
      if (running > inv_pkg::TOT_MAX) running = inv_pkg::TOT_MAX;
      held_syms[fill] = sym;
      fill++;
    end else begin
      dropped = 1'b1;
    end
    if (is_last) begin
      done.inversion_total = running[inv_pkg::TOT_W-1:0];
      done.overflow = dropped;
      tally_q.push_back(done);
      fill = 0;
      running = 0;
      dropped = 1'b0;
    end
  endtask

  always @(posedge clk) begin : watch
    tally_t want;
    if (!rst_n) begin
      fill = 0;
      running = 0;
      dropped = 1'b0;
      tally_q.delete();
      errs = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (tally_q.size() == 0) begin
          $error("unexpected result transaction: inversion_total %0d, overflow %0b",
                 out_tdata[8:0], out_tdata[9]);
          errs++;
        end else begin
          want = tally_q.pop_front();
          if (out_tdata[8:0] !== want.inversion_total) begin
            $error("inversion_total: expected %0d, actual %0d",
                   want.inversion_total, out_tdata[8:0]);
            errs++;
          end
          if (out_tdata[9] !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow, out_tdata[9]);
            errs++;
          end
          if (out_tdata[15:10] !== 6'd0) begin
            $error("padding: expected 0, actual %0h", out_tdata[15:10]);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) absorb_symbol($signed(in_tdata), in_tlast);
    end
    failures <= errs;
    awaiting <= tally_q.size();
  end

endmodule

// ===== tb/inversion_counter_tb.sv =====
module inversion_counter_tb;

  localparam int MAX_SYMBOLS = inv_pkg::MAX_SYMBOLS_DEF;
  localparam int ITEM_TARGET = 1400;
  localparam int CALM_FROM   = 1250;
  localparam int CYCLE_LIMIT = 400000;

  localparam int SHAPE_UNIFORM    = 0;
  localparam int SHAPE_NARROW     = 1;
  localparam int SHAPE_DESCENDING = 2;
  localparam int SHAPE_ASCENDING  = 3;
  localparam int SHAPE_CONSTANT   = 4;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  int unsigned failures;
  int unsigned awaiting;
  int unsigned sent = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;
  bit          gappy = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  inversion_counter #(.MAX_SYMBOLS(MAX_SYMBOLS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  inversion_counter_checker #(.MAX_SYMBOLS(MAX_SYMBOLS)) inv_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .failures(failures), .awaiting(awaiting)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("inversion_counter_tb: done, errors");
      $finish;
    end
  end

  // Receiver: stall bursts, short ready bursts and long stretches without stalls.
  initial begin : sink
    int n;
    forever begin
      if (calm) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        case ($urandom_range(0, 5))
          0, 1: begin
            out_tready <= 1'b0;
            n = $urandom_range(1, 16);
          end
          2: begin
            out_tready <= 1'b1;
            n = $urandom_range(40, 120);
          end
          default: begin
            out_tready <= 1'b1;
            n = $urandom_range(1, 16);
          end
        endcase
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_symbol(input logic [7:0] sym, input logic lst);
    if (!calm && gappy && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= sym;
    in_tlast <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    if (sent >= CALM_FROM) calm = 1'b1;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  task automatic send_sequence(input int len, input int shape);
    logic [7:0] base;
    logic [7:0] sym;
    int         span;
    base = 8'($urandom_range(0, 255));
    span = (len > 1) ? len - 1 : 1;
    gappy = ($urandom_range(0, 2) != 0);
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_NARROW:     sym = base + 8'($urandom_range(0, 3));
        SHAPE_DESCENDING: sym = 8'(127 - (i * 255) / span);
        SHAPE_ASCENDING:  sym = 8'(-128 + (i * 255) / span);
        SHAPE_CONSTANT:   sym = base;
        default:          sym = 8'($urandom_range(0, 255));
      endcase
      send_symbol(sym, i == len - 1);
    end
  endtask

  initial begin : stimulus
    int len;
    int pick;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= 8'h00;
    in_tlast <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_symbol(8'h80, 1'b1);
    send_symbol(8'h7f, 1'b1);
    send_symbol(8'h7f, 1'b0);
    send_symbol(8'h80, 1'b1);
    send_symbol(8'h80, 1'b0);
    send_symbol(8'h7f, 1'b1);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'h00, 1'b1);
    // Signed compare: -1 is below 1, so only the second pair inverts.
    send_symbol(8'hff, 1'b0);
    send_symbol(8'h01, 1'b1);
    send_symbol(8'h01, 1'b0);
    send_symbol(8'hff, 1'b1);
    send_symbol(8'h7f, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hff, 1'b0);
    send_symbol(8'h80, 1'b1);
    drain_results();

    send_sequence(MAX_SYMBOLS + 1, SHAPE_DESCENDING);
    send_sequence(MAX_SYMBOLS, SHAPE_ASCENDING);
    send_sequence(MAX_SYMBOLS + 8, SHAPE_UNIFORM);

    while (sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) len = $urandom_range(MAX_SYMBOLS, MAX_SYMBOLS + 16);
      else if (pick == 1) len = $urandom_range(17, MAX_SYMBOLS - 1);
      else if (pick < 8) len = $urandom_range(5, 16);
      else len = $urandom_range(1, 4);
      pick = $urandom_range(0, 9);
      if (pick < 4) send_sequence(len, SHAPE_UNIFORM);
      else if (pick < 6) send_sequence(len, SHAPE_NARROW);
      else if (pick == 6) send_sequence(len, SHAPE_DESCENDING);
      else if (pick == 7) send_sequence(len, SHAPE_ASCENDING);
      else if (pick == 8) send_sequence(len, SHAPE_CONSTANT);
      else send_sequence(len, $urandom_range(SHAPE_UNIFORM, SHAPE_CONSTANT));
      if (!calm && $urandom_range(0, 29) == 0) drain_results();
    end

    drain_results();
    repeat (MAX_SYMBOLS + 16) @(posedge clk);
    if (failures == 0 && awaiting == 0) begin
      $display("inversion_counter_tb: done, clean");
    end else begin
      $display("inversion_counter_tb: done, errors");
    end
    $finish;
  end

endmodule
